// ===== rtl/stbs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package stbs_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int DATA_W      = 32;
  localparam int POS_W       = 10;

  // request kinds
  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } wr_req_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } rd_req_t;

endpackage
`default_nettype wire

// ===== rtl/sorted_table_binary_search.sv =====
// sorted table with binary search
// input channel: in_valid / in_stall carry one request. req_type selects a
// load (append in_element_value; in_first_of_set restarts the table at
// index 0) or a search for in_search_key. loads give no result; a load into
// a full table is dropped and sets the sticky out_load_overflow flag.
// result channel: out_valid / out_stall carry one result per search:
// out_found, out_position (0 when not found) and out_load_overflow.
// a search runs up to log2(depth) + 1 probes, until the key is found or the
// window is empty: each probe is a read of the table ram (registered output)
// followed by the compare that picks the next midpoint.
// in_stall is high while a search runs; the block takes one request at a
// time. a finished result sits in the output register; a new request can be
// accepted while it waits, and a later search holds its result until the
// receiver drops out_stall.
// reset (rst_n low, synchronous) empties the table, clears the overflow flag
// and drops out_valid. table contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module sorted_table_binary_search (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_stall,
  input  wire                     in_req_type,
  input  wire                     in_first_of_set,
  input  wire signed [31:0]       in_element_value,
  input  wire signed [31:0]       in_search_key,
  output logic                    out_valid,
  input  wire                     out_stall,
  output logic                    out_found,
  output logic [9:0]              out_position,
  output logic                    out_load_overflow
);

  localparam int CNT_W = stbs_pkg::CNT_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_PROBE = 2'd1;
  localparam logic [1:0] S_CMP   = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             overflow_r, overflow_nxt;
  logic [CNT_W-1:0] low_r, low_nxt;
  logic [CNT_W-1:0] hix_r, hix_nxt;
  logic [CNT_W-1:0] mid_r, mid_nxt;
  logic signed [31:0] key_r, key_nxt;
  logic             hit_r, hit_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic             out_found_r, out_found_nxt;
  logic [stbs_pkg::POS_W-1:0] out_pos_r, out_pos_nxt;
  logic             out_ovf_r, out_ovf_nxt;

  stbs_pkg::wr_req_t           wr;
  stbs_pkg::rd_req_t           rd;
  logic [stbs_pkg::DATA_W-1:0] rd_data;

  logic             in_acc;
  logic [CNT_W-1:0] load_idx;
  logic [CNT_W-1:0] mid_calc;
  logic             slot_free;
  logic signed [31:0] probe;

  stbs_table_ram u_ram (
    .clk     (clk),
    .wr      (wr),
    .rd      (rd),
    .rd_data (rd_data)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && (state_r == S_IDLE);
  assign slot_free = !out_valid_r || !out_stall;
  assign load_idx  = in_first_of_set ? '0 : count_r;
  // window is [low, hix); midpoint = low + floor((hix - 1 - low) / 2)
  assign mid_calc  = low_r + ((hix_r - low_r - CNT_W'(1)) >> 1);
  assign probe     = $signed(rd_data);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    overflow_nxt  = overflow_r;
    low_nxt       = low_r;
    hix_nxt       = hix_r;
    mid_nxt       = mid_r;
    key_nxt       = key_r;
    hit_nxt       = hit_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_found_nxt = out_found_r;
    out_pos_nxt   = out_pos_r;
    out_ovf_nxt   = out_ovf_r;
    wr.en         = 1'b0;
    wr.addr       = load_idx[stbs_pkg::ADDR_W-1:0];
    wr.data       = in_element_value;
    rd.en         = 1'b0;
    rd.addr       = mid_calc[stbs_pkg::ADDR_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_req_type == stbs_pkg::REQ_LOAD) begin
            if (in_first_of_set || (count_r < CNT_W'(stbs_pkg::TABLE_DEPTH))) begin
              wr.en     = 1'b1;
              count_nxt = load_idx + CNT_W'(1);
            end else begin
              overflow_nxt = 1'b1;
            end
          end else begin
            low_nxt   = '0;
            hix_nxt   = count_r;
            key_nxt   = in_search_key;
            hit_nxt   = 1'b0;
            mid_nxt   = '0;
            state_nxt = S_PROBE;
          end
        end
      end
      S_PROBE: begin
        if (low_r < hix_r) begin
          rd.en     = 1'b1;
          mid_nxt   = mid_calc;
          state_nxt = S_CMP;
        end else begin
          mid_nxt   = '0;
          state_nxt = S_DONE;
        end
      end
      S_CMP: begin
        if (probe == key_r) begin
          hit_nxt   = 1'b1;
          state_nxt = S_DONE;
        end else if (probe > key_r) begin
          hix_nxt   = mid_r;
          state_nxt = S_PROBE;
        end else begin
          low_nxt   = mid_r + CNT_W'(1);
          state_nxt = S_PROBE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = hit_r;
          out_pos_nxt   = hit_r ? stbs_pkg::POS_W'(mid_r) : '0;
          out_ovf_nxt   = overflow_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      overflow_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      overflow_r  <= overflow_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    low_r       <= low_nxt;
    hix_r       <= hix_nxt;
    mid_r       <= mid_nxt;
    key_r       <= key_nxt;
    hit_r       <= hit_nxt;
    out_found_r <= out_found_nxt;
    out_pos_r   <= out_pos_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_found         = out_found_r;
  assign out_position      = out_pos_r;
  assign out_load_overflow = out_ovf_r;

  // a compare always follows the read that feeds it
  a_cmp_after_probe: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CMP |-> $past(state_r) == S_PROBE)
    else $error("compare without preceding read");

  // the search window stays inside the filled part of the table
  a_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PROBE || state_r == S_CMP) |-> (low_r <= hix_r && hix_r <= count_r))
    else $error("search window out of range");

  // the probed index lies inside the window
  a_mid_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CMP |-> (mid_r >= low_r && mid_r < hix_r))
    else $error("probe outside window");

  // table writes only happen between searches
  a_no_write_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> state_r == S_IDLE)
    else $error("table write during search");

  // a finished search never overwrites a result still waiting
  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_valid_r && out_stall) |=> state_r == S_DONE)
    else $error("result overwritten while stalled");

endmodule
`default_nettype wire

// ===== rtl/stbs_table_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module stbs_table_ram (
  input  wire                         clk,
  input  stbs_pkg::wr_req_t           wr,
  input  stbs_pkg::rd_req_t           rd,
  output logic [stbs_pkg::DATA_W-1:0] rd_data
);

  logic [stbs_pkg::DATA_W-1:0] mem [stbs_pkg::TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule
`default_nettype wire
